/* design/trilinear_grid_sampler_defines.svh */
// ----------------------------------------------------------------------------
// Trilinear grid sampler assertion macros
// Shorthand for the concurrent checks in the port checker.
// ----------------------------------------------------------------------------
`ifndef TRILINEAR_GRID_SAMPLER_DEFINES_SVH
`define TRILINEAR_GRID_SAMPLER_DEFINES_SVH

// A condition that must hold in the same cycle as its trigger.
`define TGS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define TGS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

/* design/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler package
// Shared types, register codes, reset values and the rounding blend step.
// ----------------------------------------------------------------------------
package tgs_pkg;

	// Default grid size in cells per axis.
	localparam int X_CELLS_DEF = 32;
	localparam int U_CELLS_DEF = 64;
	localparam int V_CELLS_DEF = 64;

	// Configuration port.
	localparam int CFG_AW = 5;
	localparam int CFG_DW = 32;

	localparam logic [2:0] REG_INV_X   = 3'd0;
	localparam logic [2:0] REG_U_LOWER = 3'd1;
	localparam logic [2:0] REG_U_UPPER = 3'd2;
	localparam logic [2:0] REG_INV_U   = 3'd3;
	localparam logic [2:0] REG_V_LOWER = 3'd4;
	localparam logic [2:0] REG_V_UPPER = 3'd5;
	localparam logic [2:0] REG_INV_V   = 3'd6;

	localparam logic [31:0] RST_INV_X   = 32'd66757;
	localparam logic [31:0] RST_U_LOWER = 32'hFFFF_8000;
	localparam logic [31:0] RST_U_UPPER = 32'h0000_8000;
	localparam logic [31:0] RST_INV_U   = 32'd4194304;
	localparam logic [31:0] RST_V_LOWER = 32'hFFFE_CCCD;
	localparam logic [31:0] RST_V_UPPER = 32'h0001_3333;
	localparam logic [31:0] RST_INV_V   = 32'd1747627;

	// Item kinds.
	localparam logic KIND_WRITE = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Weight of 1.0 with 16 fraction bits.
	localparam logic [16:0] WGT_ONE = 17'd65536;

	typedef struct packed {
		logic               kind;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_u;
		logic signed [31:0] pos_v;
		logic [5:0]         node_ix;
		logic [6:0]         node_iu;
		logic [6:0]         node_iv;
		logic signed [31:0] node_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] sample;
		logic               outside;
	} result_t;

	typedef struct packed {
		logic [31:0] inv_cell_x;
		logic [31:0] u_lower;
		logic [31:0] u_upper;
		logic [31:0] inv_cell_u;
		logic [31:0] v_lower;
		logic [31:0] v_upper;
		logic [31:0] inv_cell_v;
	} cfg_t;

	// Per-item control that travels down the pipeline.
	typedef struct packed {
		logic valid;
		logic query;
		logic outside;
		logic wr_ok;
	} ctl_t;

	// One linear step: (a*(1-w) + b*w + 0.5) rounded down, then saturated.
	function automatic logic signed [31:0] blend(input logic signed [31:0] a,
			input logic signed [31:0] b, input logic [16:0] w);
		logic signed [50:0] prod_a;
		logic signed [50:0] prod_b;
		logic signed [50:0] acc;
		logic signed [34:0] shr;
		prod_a = 51'(a) * $signed({34'd0, 17'(WGT_ONE - w)});
		prod_b = 51'(b) * $signed({34'd0, w});
		acc = prod_a + prod_b + 51'sd32768;
		shr = 35'(acc >>> 16);
		if (shr > 35'sd2147483647) begin
			return 32'sh7FFF_FFFF;
		end else if (shr < -35'sd2147483648) begin
			return 32'sh8000_0000;
		end
		return shr[31:0];
	endfunction

endpackage

/* design/tgs_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tgs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/tgs_coord.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler coordinate front end
// Bounds check, scaling, periodic wrap and clamping; stages one to five.
// ----------------------------------------------------------------------------
module tgs_coord #(
	parameter int X_CELLS = tgs_pkg::X_CELLS_DEF,
	parameter int U_CELLS = tgs_pkg::U_CELLS_DEF,
	parameter int V_CELLS = tgs_pkg::V_CELLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           item_valid,
	input  tgs_pkg::item_t                 item,
	input  tgs_pkg::cfg_t                  cfg,
	output tgs_pkg::ctl_t                  ctl,
	output logic [$clog2(X_CELLS+1)-1:0]   node_x,
	output logic [$clog2(U_CELLS+1)-1:0]   node_u,
	output logic [$clog2(V_CELLS+1)-1:0]   node_v,
	output logic [15:0]                    wgt_x,
	output logic [16:0]                    wgt_u,
	output logic [16:0]                    wgt_v,
	output logic [31:0]                    wval
);
	import tgs_pkg::*;

	localparam int NXW = $clog2(X_CELLS + 1);
	localparam int NUW = $clog2(U_CELLS + 1);
	localparam int NVW = $clog2(V_CELLS + 1);

	// Residues of byte weights for the periodic reduction.
	localparam logic [8:0] C1 = 9'(256 % X_CELLS);
	localparam logic [8:0] C2 = 9'(65536 % X_CELLS);
	localparam logic [8:0] C3 = 9'(64'd16777216 % X_CELLS);
	localparam logic [8:0] XK = 9'(X_CELLS - (64'd2147483648 % X_CELLS));
	localparam logic [26:0] RECIP = 27'(64'd134217728 / X_CELLS);

	// Stage registers.
	ctl_t                ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [31:0]  pos_x_s1;
	logic [31:0]         off_u_s1, off_v_s1;
	logic [NXW-1:0]      wix_s1, wix_s2, wix_s3, wix_s4;
	logic [NUW-1:0]      wiu_s1, wiu_s2, wiu_s3, wiu_s4;
	logic [NVW-1:0]      wiv_s1, wiv_s2, wiv_s3, wiv_s4;
	logic [31:0]         wval_s1, wval_s2, wval_s3, wval_s4, wval_s5;
	logic signed [63:0]  px_s2;
	logic [63:0]         pu_s2, pv_s2;
	logic [17:0]         sum_s3, sum_s4, qe_s4;
	logic [15:0]         wx_s3, wx_s4, wx_s5;
	logic [NUW-1:0]      cu_s3, cu_s4;
	logic [NVW-1:0]      cv_s3, cv_s4;
	logic [16:0]         wu_s3, wu_s4, wu_s5, wv_s3, wv_s4, wv_s5;
	logic [NXW-1:0]      nx_s5;
	logic [NUW-1:0]      nu_s5;
	logic [NVW-1:0]      nv_s5;

	// Stage one logic.
	ctl_t               ctl_c;
	logic [31:0]        ix_ext, iu_ext, iv_ext;
	// Stage two logic.
	logic signed [63:0] x_ext, inv_x_ext, px_c;
	// Stage three logic.
	logic [31:0]        hx;
	logic [17:0]        sum_c;
	logic [NUW-1:0]     cu_c;
	logic [NVW-1:0]     cv_c;
	logic [16:0]        wu_c, wv_c;
	// Stage four and five logic.
	logic [44:0]        qprod;
	logic [17:0]        rem_c;
	logic [NXW-1:0]     cx_c;

	// Bounds check and write index range check.
	always_comb begin
		ix_ext = 32'(item.node_ix);
		iu_ext = 32'(item.node_iu);
		iv_ext = 32'(item.node_iv);
		ctl_c.valid = item_valid;
		ctl_c.query = (item.kind == KIND_QUERY);
		ctl_c.outside = ($signed(item.pos_u) < $signed(cfg.u_lower)) ||
			($signed(item.pos_u) > $signed(cfg.u_upper)) ||
			($signed(item.pos_v) < $signed(cfg.v_lower)) ||
			($signed(item.pos_v) > $signed(cfg.v_upper));
		ctl_c.wr_ok = (ix_ext <= 32'(X_CELLS)) && (iu_ext <= 32'(U_CELLS)) &&
			(iv_ext <= 32'(V_CELLS));
	end

	// Exact products of the coordinates with the inverse cell widths.
	always_comb begin
		x_ext = 64'(pos_x_s1);
		inv_x_ext = $signed({32'd0, cfg.inv_cell_x});
		px_c = x_ext * inv_x_ext;
	end

	// Byte-wise residue sum for x; cell and weight with clamping for u and v.
	always_comb begin
		hx = px_s2[63:32];
		sum_c = 18'(hx[7:0]) + 18'(hx[15:8]) * 18'(C1) + 18'(hx[23:16]) * 18'(C2) +
			18'(hx[31:24] ^ 8'h80) * 18'(C3) + 18'(XK);
		if (pu_s2[63:32] >= 32'(U_CELLS)) begin
			cu_c = NUW'(U_CELLS - 1);
			wu_c = WGT_ONE;
		end else begin
			cu_c = pu_s2[NUW+31:32];
			wu_c = {1'b0, pu_s2[31:16]};
		end
		if (pv_s2[63:32] >= 32'(V_CELLS)) begin
			cv_c = NVW'(V_CELLS - 1);
			wv_c = WGT_ONE;
		end else begin
			cv_c = pv_s2[NVW+31:32];
			wv_c = {1'b0, pv_s2[31:16]};
		end
	end

	// Quotient estimate and remainder with one correction step.
	always_comb begin
		qprod = 45'(sum_s3) * 45'(RECIP);
		rem_c = sum_s4 - 18'(qe_s4 * 18'(X_CELLS));
		if (rem_c >= 18'(X_CELLS)) begin
			rem_c = rem_c - 18'(X_CELLS);
		end
		cx_c = rem_c[NXW-1:0];
	end

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_c;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Data pipeline.
	always_ff @(posedge clk) begin
		if (adv) begin
			pos_x_s1 <= item.pos_x;
			off_u_s1 <= 32'(item.pos_u - cfg.u_lower);
			off_v_s1 <= 32'(item.pos_v - cfg.v_lower);
			wix_s1 <= ix_ext[NXW-1:0];
			wiu_s1 <= iu_ext[NUW-1:0];
			wiv_s1 <= iv_ext[NVW-1:0];
			wval_s1 <= item.node_value;

			px_s2 <= px_c;
			pu_s2 <= {32'd0, off_u_s1} * {32'd0, cfg.inv_cell_u};
			pv_s2 <= {32'd0, off_v_s1} * {32'd0, cfg.inv_cell_v};
			wix_s2 <= wix_s1;
			wiu_s2 <= wiu_s1;
			wiv_s2 <= wiv_s1;
			wval_s2 <= wval_s1;

			sum_s3 <= sum_c;
			wx_s3 <= px_s2[31:16];
			cu_s3 <= cu_c;
			wu_s3 <= wu_c;
			cv_s3 <= cv_c;
			wv_s3 <= wv_c;
			wix_s3 <= wix_s2;
			wiu_s3 <= wiu_s2;
			wiv_s3 <= wiv_s2;
			wval_s3 <= wval_s2;

			sum_s4 <= sum_s3;
			qe_s4 <= qprod[44:27];
			wx_s4 <= wx_s3;
			cu_s4 <= cu_s3;
			wu_s4 <= wu_s3;
			cv_s4 <= cv_s3;
			wv_s4 <= wv_s3;
			wix_s4 <= wix_s3;
			wiu_s4 <= wiu_s3;
			wiv_s4 <= wiv_s3;
			wval_s4 <= wval_s3;

			nx_s5 <= ctl_s4.query ? cx_c : wix_s4;
			nu_s5 <= ctl_s4.query ? cu_s4 : wiu_s4;
			nv_s5 <= ctl_s4.query ? cv_s4 : wiv_s4;
			wx_s5 <= wx_s4;
			wu_s5 <= wu_s4;
			wv_s5 <= wv_s4;
			wval_s5 <= wval_s4;
		end
	end

	assign ctl = ctl_s5;
	assign node_x = nx_s5;
	assign node_u = nu_s5;
	assign node_v = nv_s5;
	assign wgt_x = wx_s5;
	assign wgt_u = wu_s5;
	assign wgt_v = wv_s5;
	assign wval = wval_s5;

endmodule

/* design/tgs_fetch.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler corner fetch
// Eight parity banks; a write fills one bank, a query reads all eight corners.
// ----------------------------------------------------------------------------
module tgs_fetch #(
	parameter int X_CELLS = tgs_pkg::X_CELLS_DEF,
	parameter int U_CELLS = tgs_pkg::U_CELLS_DEF,
	parameter int V_CELLS = tgs_pkg::V_CELLS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  tgs_pkg::ctl_t                 ctl_in,
	input  logic [$clog2(X_CELLS+1)-1:0]  node_x,
	input  logic [$clog2(U_CELLS+1)-1:0]  node_u,
	input  logic [$clog2(V_CELLS+1)-1:0]  node_v,
	input  logic [15:0]                   wgt_x_in,
	input  logic [16:0]                   wgt_u_in,
	input  logic [16:0]                   wgt_v_in,
	input  logic [31:0]                   wval,
	output tgs_pkg::ctl_t                 ctl,
	output logic [7:0][31:0]              corner,
	output logic [15:0]                   wgt_x,
	output logic [16:0]                   wgt_u,
	output logic [16:0]                   wgt_v
);
	import tgs_pkg::*;

	localparam int NXW = $clog2(X_CELLS + 1);
	localparam int NUW = $clog2(U_CELLS + 1);
	localparam int NVW = $clog2(V_CELLS + 1);
	localparam int HX = (X_CELLS + 2) / 2;
	localparam int HU = (U_CELLS + 2) / 2;
	localparam int HV = (V_CELLS + 2) / 2;
	localparam int HXW = $clog2(HX);
	localparam int HUW = $clog2(HU);
	localparam int HVW = $clog2(HV);
	localparam int TW = $clog2(HU * HV);
	localparam int BANK_DEPTH = HX * HU * HV;
	localparam int AW = $clog2(BANK_DEPTH);

	ctl_t            ctl_s6, ctl_s7, ctl_s8;
	logic [HXW-1:0]  hx_s6 [2];
	logic [HUW-1:0]  hu_s6 [2];
	logic [HVW-1:0]  hv_s6 [2];
	logic [HXW-1:0]  hx_s7 [2];
	logic [TW-1:0]   t_s7 [2][2];
	logic [2:0]      par_s6, par_s7, par_s8;
	logic [15:0]     wx_s6, wx_s7, wx_s8;
	logic [16:0]     wu_s6, wu_s7, wu_s8, wv_s6, wv_s7, wv_s8;
	logic [31:0]     wval_s6, wval_s7;

	logic [HXW-1:0]  hx_c [2];
	logic [HUW-1:0]  hu_c [2];
	logic [HVW-1:0]  hv_c [2];
	logic [NXW:0]    sx;
	logic [NUW:0]    su;
	logic [NVW:0]    sv;
	logic [31:0]     rd_data [8];

	// Half indices: a query takes the node of each parity in {n, n+1}.
	always_comb begin
		for (int p = 0; p < 2; p++) begin
			sx = {1'b0, node_x} + {{NXW{1'b0}}, ctl_in.query & (node_x[0] ^ p[0])};
			su = {1'b0, node_u} + {{NUW{1'b0}}, ctl_in.query & (node_u[0] ^ p[0])};
			sv = {1'b0, node_v} + {{NVW{1'b0}}, ctl_in.query & (node_v[0] ^ p[0])};
			hx_c[p] = sx[HXW:1];
			hu_c[p] = su[HUW:1];
			hv_c[p] = sv[HVW:1];
		end
	end

	// Control pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
		end else if (adv) begin
			ctl_s6 <= ctl_in;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
		end
	end

	// Address pipeline and side data.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int p = 0; p < 2; p++) begin
				hx_s6[p] <= hx_c[p];
				hu_s6[p] <= hu_c[p];
				hv_s6[p] <= hv_c[p];
				hx_s7[p] <= hx_s6[p];
				for (int r = 0; r < 2; r++) begin
					t_s7[p][r] <= TW'(hu_s6[p]) + TW'(HU) * TW'(hv_s6[r]);
				end
			end
			par_s6 <= {node_x[0], node_u[0], node_v[0]};
			par_s7 <= par_s6;
			par_s8 <= par_s7;
			wx_s6 <= wgt_x_in;
			wu_s6 <= wgt_u_in;
			wv_s6 <= wgt_v_in;
			wx_s7 <= wx_s6;
			wu_s7 <= wu_s6;
			wv_s7 <= wv_s6;
			wx_s8 <= wx_s7;
			wu_s8 <= wu_s7;
			wv_s8 <= wv_s7;
			wval_s6 <= wval;
			wval_s7 <= wval_s6;
		end
	end

	// One bank per parity pattern {x, u, v}.
	for (genvar b = 0; b < 8; b++) begin : g_bank
		localparam int PX = b / 4;
		localparam int PU = (b / 2) % 2;
		localparam int PV = b % 2;
		logic [AW-1:0] addr;
		logic          we;

		assign addr = AW'(hx_s7[PX]) + AW'(HX) * AW'(t_s7[PU][PV]);
		assign we = adv && ctl_s7.valid && !ctl_s7.query && ctl_s7.wr_ok &&
			(par_s7 == 3'(b));

		tgs_ram #(
			.WIDTH(32),
			.DEPTH(BANK_DEPTH)
		) u_ram (
			.clk  (clk),
			.we   (we),
			.waddr(addr),
			.wdata(wval_s7),
			.re   (adv),
			.raddr(addr),
			.rdata(rd_data[b])
		);
	end

	// Route banks back to corners {dx, du, dv}.
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			corner[k] = rd_data[3'(k) ^ par_s8];
		end
	end

	assign ctl = ctl_s8;
	assign wgt_x = wx_s8;
	assign wgt_u = wu_s8;
	assign wgt_v = wv_s8;

endmodule

/* design/tgs_blend.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler blend tree
// Three registered levels of linear steps: along v, along u, along x.
// ----------------------------------------------------------------------------
module tgs_blend (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  tgs_pkg::ctl_t     ctl,
	input  logic [7:0][31:0]  corner,
	input  logic [15:0]       wgt_x,
	input  logic [16:0]       wgt_u,
	input  logic [16:0]       wgt_v,
	output logic              result_valid,
	output tgs_pkg::result_t  result
);
	import tgs_pkg::*;

	ctl_t               ctl_s9, ctl_s10;
	logic               valid_s11;
	logic signed [31:0] av_s9 [4];
	logic signed [31:0] au_s10 [2];
	logic [16:0]        wu_s9;
	logic [15:0]        wx_s9, wx_s10;
	result_t            res_s11;

	// Control pipeline; only queries produce a result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s9 <= '0;
			ctl_s10 <= '0;
			valid_s11 <= 1'b0;
		end else if (adv) begin
			ctl_s9 <= ctl;
			ctl_s10 <= ctl_s9;
			valid_s11 <= ctl_s10.valid && ctl_s10.query;
		end
	end

	// Blend levels; an outside query gives zero.
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 4; i++) begin
				av_s9[i] <= blend($signed(corner[2*i]), $signed(corner[2*i+1]), wgt_v);
			end
			wu_s9 <= wgt_u;
			wx_s9 <= wgt_x;
			for (int d = 0; d < 2; d++) begin
				au_s10[d] <= blend(av_s9[2*d], av_s9[2*d+1], wu_s9);
			end
			wx_s10 <= wx_s9;
			res_s11.sample <= ctl_s10.outside ? 32'sd0 :
				blend(au_s10[0], au_s10[1], {1'b0, wx_s10});
			res_s11.outside <= ctl_s10.outside;
		end
	end

	assign result_valid = valid_s11;
	assign result = res_s11;

endmodule

/* design/trilinear_grid_sampler.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler: eleven register stages in the coordinate front end, corner fetch and blend tree.
// One item per clock unless a result stalls; each of eight parity banks serves one corner per query.
// Reset clears the pipeline valid bits and loads the register defaults; grid contents are kept.
// ----------------------------------------------------------------------------
module trilinear_grid_sampler #(
	parameter int X_CELLS = tgs_pkg::X_CELLS_DEF,
	parameter int U_CELLS = tgs_pkg::U_CELLS_DEF,
	parameter int V_CELLS = tgs_pkg::V_CELLS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tgs_pkg::CFG_AW-1:0]  paddr,
	input  logic [tgs_pkg::CFG_DW-1:0]  pwdata,
	output logic [tgs_pkg::CFG_DW-1:0]  prdata,
	output logic                        pready,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  tgs_pkg::item_t              item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output tgs_pkg::result_t            result
);
	import tgs_pkg::*;

	localparam int NXW = $clog2(X_CELLS + 1);
	localparam int NUW = $clog2(U_CELLS + 1);
	localparam int NVW = $clog2(V_CELLS + 1);

	cfg_t            cfg_q;
	logic [2:0]      reg_idx;
	logic            cfg_wr;
	logic            adv;
	ctl_t            ctl_co, ctl_fe;
	logic [NXW-1:0]  node_x;
	logic [NUW-1:0]  node_u;
	logic [NVW-1:0]  node_v;
	logic [15:0]     wx_co, wx_fe;
	logic [16:0]     wu_co, wu_fe, wv_co, wv_fe;
	logic [31:0]     wval;
	logic [7:0][31:0] corner;

	// The whole pipeline moves unless a finished result is held back.
	assign adv = !(result_valid && result_stall);
	assign item_stall = !adv;

	// Register file on the configuration port.
	assign reg_idx = paddr[CFG_AW-1:2];
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.inv_cell_x <= RST_INV_X;
			cfg_q.u_lower <= RST_U_LOWER;
			cfg_q.u_upper <= RST_U_UPPER;
			cfg_q.inv_cell_u <= RST_INV_U;
			cfg_q.v_lower <= RST_V_LOWER;
			cfg_q.v_upper <= RST_V_UPPER;
			cfg_q.inv_cell_v <= RST_INV_V;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_INV_X:   cfg_q.inv_cell_x <= pwdata;
				REG_U_LOWER: cfg_q.u_lower <= pwdata;
				REG_U_UPPER: cfg_q.u_upper <= pwdata;
				REG_INV_U:   cfg_q.inv_cell_u <= pwdata;
				REG_V_LOWER: cfg_q.v_lower <= pwdata;
				REG_V_UPPER: cfg_q.v_upper <= pwdata;
				REG_INV_V:   cfg_q.inv_cell_v <= pwdata;
				default: begin
				end
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		case (reg_idx)
			REG_INV_X:   prdata = cfg_q.inv_cell_x;
			REG_U_LOWER: prdata = cfg_q.u_lower;
			REG_U_UPPER: prdata = cfg_q.u_upper;
			REG_INV_U:   prdata = cfg_q.inv_cell_u;
			REG_V_LOWER: prdata = cfg_q.v_lower;
			REG_V_UPPER: prdata = cfg_q.v_upper;
			REG_INV_V:   prdata = cfg_q.inv_cell_v;
			default:     prdata = '0;
		endcase
	end

	tgs_coord #(
		.X_CELLS(X_CELLS),
		.U_CELLS(U_CELLS),
		.V_CELLS(V_CELLS)
	) u_coord (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.item_valid(item_valid),
		.item      (item),
		.cfg       (cfg_q),
		.ctl       (ctl_co),
		.node_x    (node_x),
		.node_u    (node_u),
		.node_v    (node_v),
		.wgt_x     (wx_co),
		.wgt_u     (wu_co),
		.wgt_v     (wv_co),
		.wval      (wval)
	);

	tgs_fetch #(
		.X_CELLS(X_CELLS),
		.U_CELLS(U_CELLS),
		.V_CELLS(V_CELLS)
	) u_fetch (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.ctl_in  (ctl_co),
		.node_x  (node_x),
		.node_u  (node_u),
		.node_v  (node_v),
		.wgt_x_in(wx_co),
		.wgt_u_in(wu_co),
		.wgt_v_in(wv_co),
		.wval    (wval),
		.ctl     (ctl_fe),
		.corner  (corner),
		.wgt_x   (wx_fe),
		.wgt_u   (wu_fe),
		.wgt_v   (wv_fe)
	);

	tgs_blend u_blend (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.ctl         (ctl_fe),
		.corner      (corner),
		.wgt_x       (wx_fe),
		.wgt_u       (wu_fe),
		.wgt_v       (wv_fe),
		.result_valid(result_valid),
		.result      (result)
	);

endmodule

/* design/tgs_checker.sv */
// ----------------------------------------------------------------------------
// Trilinear grid sampler port checker
// Checks transaction rules and result properties seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "trilinear_grid_sampler_defines.svh"

module tgs_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             item_stall,
	input logic             result_valid,
	input logic             result_stall,
	input tgs_pkg::result_t result
);

	// A stalled result transaction stays offered.
	`TGS_ASSERT_NEXT(a_rsp_hold, result_valid && result_stall, result_valid, "result dropped while stalled")

	// A stalled result payload does not change.
	`TGS_ASSERT_NEXT(a_rsp_stable, result_valid && result_stall, $stable(result), "result changed while stalled")

	// An outside query always reports a zero sample.
	`TGS_ASSERT_SAME(a_outside_zero, result_valid && result.outside, result.sample == 32'sd0, "outside query with nonzero sample")

	// Input is held back only by a blocked result.
	`TGS_ASSERT_SAME(a_stall_cause, item_stall, result_valid && result_stall, "input stalled without output back-pressure")

endmodule

bind trilinear_grid_sampler tgs_checker u_checker (.*);
